>>> rtl/per_core_utilization_tracker_macros.svh
// Assertion macros for the per-core utilization tracker.
// Included by the RTL files that check their own logic; needs clk_i and rst_ni in scope.
`ifndef PER_CORE_UTILIZATION_TRACKER_MACROS_SVH
`define PER_CORE_UTILIZATION_TRACKER_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define PCUT_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pcut assertion failed");
// Check a property on edges where a condition holds.
`define PCUT_ASSERT_IF(label, cond, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error("pcut conditional assertion failed");
`else
`define PCUT_ASSERT(label, prop)
`define PCUT_ASSERT_IF(label, cond, prop)
`endif

`endif

>>> rtl/pcut_pkg.sv
// Shared types, widths and constants of the per-core utilization tracker.
// No dependencies; the RTL modules and interfaces refer to it by scoped names, the testbench imports it.
package pcut_pkg;

  localparam int CORES   = 8;
  localparam int ENTRIES = CORES + 1;
  localparam int ENTRY_W = $clog2(ENTRIES);

  localparam int IDX_W   = 8;
  localparam int TICK_W  = 64;
  localparam int BUSY_W  = 14;
  localparam int QBITS   = BUSY_W;
  localparam int ALU_W   = TICK_W + QBITS;

  // Counters folded into the running sum after the idle counter is loaded.
  localparam int NUM_OPS = 7;
  // 10000 = 2^13 + 2^10 + 2^9 + 2^8 + 2^4: seed with the top term, add four more.
  localparam int FIRST_SHIFT = 13;
  localparam int SCALE_ADDS  = 4;
  localparam int SH_W        = $clog2(SCALE_ADDS);
  localparam int SHAMT_W     = 4;
  localparam int CNT_W       = $clog2(QBITS);
  localparam int BUSY_MAX    = 10000;

  typedef logic [TICK_W-1:0]  tick_t;
  typedef logic [BUSY_W-1:0]  busy_t;
  typedef logic [ENTRY_W-1:0] entry_idx_t;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SUM   = 8'b0000_0010,
    S_DT    = 8'b0000_0100,
    S_DI    = 8'b0000_1000,
    S_CMP   = 8'b0001_0000,
    S_SCALE = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    alu_op_e          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             borrow;
  } alu_rsp_t;

  typedef struct packed {
    tick_t idle;
    tick_t total;
    busy_t busy;
  } entry_t;

  typedef struct packed {
    logic       en;
    entry_idx_t idx;
    entry_t     ent;
  } wr_t;

  // Shift of the term added in each scaling step.
  function automatic logic [SHAMT_W-1:0] scale_shift(input logic [SH_W-1:0] step);
    logic [SHAMT_W-1:0] sh;
    unique case (step)
      2'd0:    sh = 4'd10;
      2'd1:    sh = 4'd9;
      2'd2:    sh = 4'd8;
      default: sh = 4'd4;
    endcase
    return sh;
  endfunction

endpackage

>>> rtl/pcut_in_if.sv
// Sample channel: core index plus eight cumulative tick counters.
// Depends on pcut_pkg for field widths.
interface pcut_in_if;
  logic                       valid;
  logic                       ready;
  logic [pcut_pkg::IDX_W-1:0] core_index;
  pcut_pkg::tick_t            user_ticks;
  pcut_pkg::tick_t            nice_ticks;
  pcut_pkg::tick_t            system_ticks;
  pcut_pkg::tick_t            idle_ticks;
  pcut_pkg::tick_t            iowait_ticks;
  pcut_pkg::tick_t            irq_ticks;
  pcut_pkg::tick_t            softirq_ticks;
  pcut_pkg::tick_t            steal_ticks;

  modport source (
    output valid, core_index, user_ticks, nice_ticks, system_ticks, idle_ticks,
           iowait_ticks, irq_ticks, softirq_ticks, steal_ticks,
    input  ready
  );
  modport sink (
    input  valid, core_index, user_ticks, nice_ticks, system_ticks, idle_ticks,
           iowait_ticks, irq_ticks, softirq_ticks, steal_ticks,
    output ready
  );
endinterface

>>> rtl/pcut_out_if.sv
// Result channel: entry used, busy share in hundredths of a percent, flags.
// Depends on pcut_pkg for field widths.
interface pcut_out_if;
  logic                       valid;
  logic                       ready;
  logic [pcut_pkg::IDX_W-1:0] entry_used;
  pcut_pkg::busy_t            busy_hundredths;
  logic                       updated;
  logic                       unknown_core;

  modport source (
    output valid, entry_used, busy_hundredths, updated, unknown_core,
    input  ready
  );
  modport sink (
    input  valid, entry_used, busy_hundredths, updated, unknown_core,
    output ready
  );
endinterface

>>> rtl/pcut_alu.sv
// Shared add/subtract unit used by every arithmetic step of the sequencer.
// Depends on pcut_pkg for the request and response structs.
module pcut_alu (
  input  pcut_pkg::alu_req_t req_i,
  output pcut_pkg::alu_rsp_t rsp_o
);

  logic [pcut_pkg::ALU_W-1:0] b_eff;
  logic [pcut_pkg::ALU_W:0]   sum;
  logic                       is_sub;

  assign is_sub = (req_i.op == pcut_pkg::ALU_SUB);
  assign b_eff  = is_sub ? ~req_i.b : req_i.b;
  assign sum    = {1'b0, req_i.a} + {1'b0, b_eff} + {{pcut_pkg::ALU_W{1'b0}}, is_sub};

  assign rsp_o.res    = sum[pcut_pkg::ALU_W-1:0];
  // No carry out of a - b means a < b.
  assign rsp_o.borrow = is_sub & ~sum[pcut_pkg::ALU_W];

endmodule

>>> rtl/pcut_store.sv
// Per-entry history: previous idle sum, previous total sum and last busy value.
// Depends on pcut_pkg; cleared to zero by reset, one read and one write port.
module pcut_store (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pcut_pkg::entry_idx_t rd_idx_i,
  output pcut_pkg::entry_t     rd_o,
  input  pcut_pkg::wr_t        wr_i
);

  pcut_pkg::entry_t entries_q [pcut_pkg::ENTRIES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pcut_pkg::ENTRIES; i++) begin
        entries_q[i] <= '0;
      end
    end else if (wr_i.en) begin
      entries_q[wr_i.idx] <= wr_i.ent;
    end
  end

  assign rd_o = entries_q[rd_idx_i];

endmodule

>>> rtl/per_core_utilization_tracker.sv
// Channel   Dir  Handshake    Payload
// in_i      in   valid/ready  core_index, user..steal_ticks (8 x 64 bit)
// out_o     out  valid/ready  entry_used, busy_hundredths, updated, unknown_core
//
// One sample runs from transfer to the next ready: summing the counters, deltas and
// compare, scaling by 10000 and 14 radix-2 divide steps, all on the single shared
// add/subtract unit, plus write-back and idle. A zero interval goes from the deltas
// to write-back, an idle delta above the total straight from compare.
// Reset clears the sequencer, the output valid flag and the history table at once.
// Write-back waits while a previous result still sits unread in the output register.
// Depends on pcut_pkg, pcut_in_if, pcut_out_if, pcut_alu and pcut_store.
`include "per_core_utilization_tracker_macros.svh"

module per_core_utilization_tracker (
  input  logic       clk_i,
  input  logic       rst_ni,
  pcut_in_if.sink    in_i,
  pcut_out_if.source out_o
);

  pcut_pkg::state_e              state_q, state_d;
  logic [pcut_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  pcut_pkg::entry_idx_t          idx_q, idx_d;
  logic                          unk_q, unk_d;
  logic                          upd_q, upd_d;
  pcut_pkg::tick_t               ops_q [pcut_pkg::NUM_OPS];
  pcut_pkg::tick_t               ops_d [pcut_pkg::NUM_OPS];
  logic [pcut_pkg::ALU_W-1:0]    acc_q, acc_d;
  pcut_pkg::tick_t               sidle_q, sidle_d;
  pcut_pkg::tick_t               tot_q, tot_d;
  pcut_pkg::tick_t               dt_q, dt_d;
  pcut_pkg::tick_t               di_q, di_d;
  pcut_pkg::tick_t               num_q, num_d;
  pcut_pkg::tick_t               rem_q, rem_d;
  pcut_pkg::busy_t               low_q, low_d;

  logic                          out_valid_q, out_valid_d;
  logic [pcut_pkg::IDX_W-1:0]    out_entry_q, out_entry_d;
  pcut_pkg::busy_t               out_busy_q, out_busy_d;
  logic                          out_upd_q, out_upd_d;
  logic                          out_unk_q, out_unk_d;

  pcut_pkg::alu_req_t            alu_req;
  pcut_pkg::alu_rsp_t            alu_rsp;
  pcut_pkg::entry_t              prev;
  pcut_pkg::wr_t                 wr;
  logic                          in_xfer;
  logic                          unknown;

  pcut_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  pcut_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (idx_q),
    .rd_o     (prev),
    .wr_i     (wr)
  );

  assign in_i.ready = (state_q == pcut_pkg::S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign unknown    = in_i.core_index > pcut_pkg::IDX_W'(pcut_pkg::CORES);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    unk_d       = unk_q;
    upd_d       = upd_q;
    ops_d       = ops_q;
    acc_d       = acc_q;
    sidle_d     = sidle_q;
    tot_d       = tot_q;
    dt_d        = dt_q;
    di_d        = di_q;
    num_d       = num_q;
    rem_d       = rem_q;
    low_d       = low_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_entry_d = out_entry_q;
    out_busy_d  = out_busy_q;
    out_upd_d   = out_upd_q;
    out_unk_d   = out_unk_q;
    alu_req.op  = pcut_pkg::ALU_ADD;
    alu_req.a   = acc_q;
    alu_req.b   = '0;
    wr.en       = 1'b0;
    wr.idx      = idx_q;
    wr.ent.idle  = sidle_q;
    wr.ent.total = tot_q;
    wr.ent.busy  = low_q;

    unique case (state_q)
      pcut_pkg::S_IDLE: begin
        if (in_xfer) begin
          idx_d    = unknown ? '0 : in_i.core_index[pcut_pkg::ENTRY_W-1:0];
          unk_d    = unknown;
          acc_d    = pcut_pkg::ALU_W'(in_i.idle_ticks);
          ops_d[0] = in_i.iowait_ticks;
          ops_d[1] = in_i.user_ticks;
          ops_d[2] = in_i.nice_ticks;
          ops_d[3] = in_i.system_ticks;
          ops_d[4] = in_i.irq_ticks;
          ops_d[5] = in_i.softirq_ticks;
          ops_d[6] = in_i.steal_ticks;
          cnt_d    = '0;
          state_d  = pcut_pkg::S_SUM;
        end
      end
      pcut_pkg::S_SUM: begin
        alu_req.a = pcut_pkg::ALU_W'(acc_q[pcut_pkg::TICK_W-1:0]);
        alu_req.b = pcut_pkg::ALU_W'(ops_q[0]);
        acc_d     = pcut_pkg::ALU_W'(alu_rsp.res[pcut_pkg::TICK_W-1:0]);
        // Advance the operand queue by one.
        for (int i = 0; i < pcut_pkg::NUM_OPS - 1; i++) begin
          ops_d[i] = ops_q[i + 1];
        end
        ops_d[pcut_pkg::NUM_OPS-1] = '0;
        if (cnt_q == '0) begin
          sidle_d = alu_rsp.res[pcut_pkg::TICK_W-1:0];
        end
        if (cnt_q == pcut_pkg::CNT_W'(pcut_pkg::NUM_OPS - 1)) begin
          cnt_d   = '0;
          state_d = pcut_pkg::S_DT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      pcut_pkg::S_DT: begin
        alu_req.op = pcut_pkg::ALU_SUB;
        alu_req.a  = pcut_pkg::ALU_W'(acc_q[pcut_pkg::TICK_W-1:0]);
        alu_req.b  = pcut_pkg::ALU_W'(prev.total);
        dt_d       = alu_rsp.res[pcut_pkg::TICK_W-1:0];
        tot_d      = acc_q[pcut_pkg::TICK_W-1:0];
        state_d    = pcut_pkg::S_DI;
      end
      pcut_pkg::S_DI: begin
        alu_req.op = pcut_pkg::ALU_SUB;
        alu_req.a  = pcut_pkg::ALU_W'(sidle_q);
        alu_req.b  = pcut_pkg::ALU_W'(prev.idle);
        di_d       = alu_rsp.res[pcut_pkg::TICK_W-1:0];
        // Zero interval: keep history, report the stored value.
        if (dt_q == '0) begin
          upd_d   = 1'b0;
          state_d = pcut_pkg::S_DONE;
        end else begin
          upd_d   = 1'b1;
          state_d = pcut_pkg::S_CMP;
        end
      end
      pcut_pkg::S_CMP: begin
        alu_req.op = pcut_pkg::ALU_SUB;
        alu_req.a  = pcut_pkg::ALU_W'(dt_q);
        alu_req.b  = pcut_pkg::ALU_W'(di_q);
        if (alu_rsp.borrow) begin
          // Idle delta above total delta: busy saturates to zero.
          low_d   = '0;
          state_d = pcut_pkg::S_DONE;
        end else begin
          num_d   = alu_rsp.res[pcut_pkg::TICK_W-1:0];
          acc_d   = pcut_pkg::ALU_W'(alu_rsp.res[pcut_pkg::TICK_W-1:0])
                    << pcut_pkg::FIRST_SHIFT;
          cnt_d   = '0;
          state_d = pcut_pkg::S_SCALE;
        end
      end
      pcut_pkg::S_SCALE: begin
        alu_req.a = acc_q;
        alu_req.b = pcut_pkg::ALU_W'(num_q)
                    << pcut_pkg::scale_shift(cnt_q[pcut_pkg::SH_W-1:0]);
        acc_d     = alu_rsp.res;
        if (cnt_q == pcut_pkg::CNT_W'(pcut_pkg::SCALE_ADDS - 1)) begin
          // Quotient fits in QBITS, so the top part is already below the divisor.
          rem_d   = alu_rsp.res[pcut_pkg::ALU_W-1:pcut_pkg::QBITS];
          low_d   = alu_rsp.res[pcut_pkg::QBITS-1:0];
          cnt_d   = '0;
          state_d = pcut_pkg::S_DIV;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      pcut_pkg::S_DIV: begin
        alu_req.op = pcut_pkg::ALU_SUB;
        alu_req.a  = pcut_pkg::ALU_W'({rem_q, low_q[pcut_pkg::QBITS-1]});
        alu_req.b  = pcut_pkg::ALU_W'(dt_q);
        if (alu_rsp.borrow) begin
          rem_d = {rem_q[pcut_pkg::TICK_W-2:0], low_q[pcut_pkg::QBITS-1]};
        end else begin
          rem_d = alu_rsp.res[pcut_pkg::TICK_W-1:0];
        end
        // Shift the next dividend bit out and the quotient bit in.
        low_d = {low_q[pcut_pkg::QBITS-2:0], ~alu_rsp.borrow};
        if (cnt_q == pcut_pkg::CNT_W'(pcut_pkg::QBITS - 1)) begin
          state_d = pcut_pkg::S_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      pcut_pkg::S_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_q || out_o.ready) begin
          wr.en       = upd_q;
          out_valid_d = 1'b1;
          out_entry_d = pcut_pkg::IDX_W'(idx_q);
          out_busy_d  = upd_q ? low_q : prev.busy;
          out_upd_d   = upd_q;
          out_unk_d   = unk_q;
          state_d     = pcut_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pcut_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcut_pkg::S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    unk_q       <= unk_d;
    upd_q       <= upd_d;
    ops_q       <= ops_d;
    acc_q       <= acc_d;
    sidle_q     <= sidle_d;
    tot_q       <= tot_d;
    dt_q        <= dt_d;
    di_q        <= di_d;
    num_q       <= num_d;
    rem_q       <= rem_d;
    low_q       <= low_d;
    out_entry_q <= out_entry_d;
    out_busy_q  <= out_busy_d;
    out_upd_q   <= out_upd_d;
    out_unk_q   <= out_unk_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.entry_used      = out_entry_q;
  assign out_o.busy_hundredths = out_busy_q;
  assign out_o.updated         = out_upd_q;
  assign out_o.unknown_core    = out_unk_q;

  `PCUT_ASSERT_IF(a_xfer_starts_sum, in_xfer, ##1 (state_q == pcut_pkg::S_SUM))
  `PCUT_ASSERT_IF(a_rise_from_done, $rose(out_valid_q), $past(state_q == pcut_pkg::S_DONE))
  `PCUT_ASSERT_IF(a_busy_in_range, out_valid_q, out_busy_q <= pcut_pkg::BUSY_W'(pcut_pkg::BUSY_MAX))
  `PCUT_ASSERT_IF(a_rem_below_div, state_q == pcut_pkg::S_DIV, rem_q < dt_q)
  `PCUT_ASSERT(a_write_only_done, !wr.en || (state_q == pcut_pkg::S_DONE))

endmodule

>>> verif/tb.sv
// Self-checking testbench for per_core_utilization_tracker: directed and random tick samples,
// busy share predicted per table entry and checked in order. Depends on pcut_pkg,
// pcut_in_if, pcut_out_if and the RTL of the tracker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcut_pkg::*;

  // Slots of the eight tick counters inside one sample.
  localparam int C_USER    = 0;
  localparam int C_NICE    = 1;
  localparam int C_SYSTEM  = 2;
  localparam int C_IDLE    = 3;
  localparam int C_IOWAIT  = 4;
  localparam int C_IRQ     = 5;
  localparam int C_SOFTIRQ = 6;
  localparam int C_STEAL   = 7;

  localparam int NUM_RANDOM   = 1600;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTED = 30;

  typedef logic [7:0][TICK_W-1:0] tick_set_t;

  typedef struct packed {
    logic [IDX_W-1:0] core_index;
    tick_set_t        ticks;
  } sample_t;

  typedef struct packed {
    logic [IDX_W-1:0] entry_used;
    busy_t            busy;
    logic             updated;
    logic             unknown_core;
  } share_report_t;

  typedef enum int {
    K_STEADY,
    K_HOLD,
    K_JUMP,
    K_IDLE_HEAVY,
    K_STRAY_INDEX,
    K_NOISE
  } sample_kind_e;

  // Per-entry history of idle and total sums, and the busy share each entry reports.
  class share_board;
    tick_t         idle_hist  [ENTRIES];
    tick_t         total_hist [ENTRIES];
    busy_t         share_hist [ENTRIES];
    share_report_t pending [$];
    int            n_errors;
    int            n_checked;
    int            n_updates;
    int            n_held;
    int            n_idle_heavy;
    int            n_stray;

    function new();
      foreach (idle_hist[i]) begin
        idle_hist[i]  = '0;
        total_hist[i] = '0;
        share_hist[i] = '0;
      end
      n_errors     = 0;
      n_checked    = 0;
      n_updates    = 0;
      n_held       = 0;
      n_idle_heavy = 0;
      n_stray      = 0;
    endfunction

    function void record_sample(sample_t s);
      logic          stray;
      int unsigned   e;
      tick_t         idle_sum;
      tick_t         total_sum;
      tick_t         d_total;
      tick_t         d_idle;
      logic [127:0]  scaled;
      share_report_t r;
      stray     = (s.core_index > CORES);
      e         = stray ? 0 : s.core_index;
      idle_sum  = s.ticks[C_IDLE] + s.ticks[C_IOWAIT];
      total_sum = idle_sum + s.ticks[C_USER] + s.ticks[C_NICE] + s.ticks[C_SYSTEM]
                + s.ticks[C_IRQ] + s.ticks[C_SOFTIRQ] + s.ticks[C_STEAL];
      d_total   = total_sum - total_hist[e];
      d_idle    = idle_sum - idle_hist[e];
      if (d_total != '0) begin
        if (d_idle > d_total) begin
          share_hist[e] = '0;
          n_idle_heavy++;
        end else begin
          scaled = {64'd0, d_total - d_idle} * 128'(BUSY_MAX);
          share_hist[e] = busy_t'(scaled / {64'd0, d_total});
        end
        idle_hist[e]  = idle_sum;
        total_hist[e] = total_sum;
        n_updates++;
      end else begin
        n_held++;
      end
      if (stray) n_stray++;
      r.entry_used   = IDX_W'(e);
      r.busy         = share_hist[e];
      r.updated      = (d_total != '0);
      r.unknown_core = stray;
      pending.push_back(r);
    endfunction

    function void field_check(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        n_errors++;
        if (n_errors <= MAX_REPORTED)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_report(share_report_t got);
      share_report_t want;
      n_checked++;
      if (pending.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTED)
          $display("%0t: unexpected report, expected none, actual entry %0d busy %0d",
                   $time, got.entry_used, got.busy);
        return;
      end
      want = pending.pop_front();
      field_check("entry_used", want.entry_used, got.entry_used);
      field_check("busy_hundredths", want.busy, got.busy);
      field_check("updated", want.updated, got.updated);
      field_check("unknown_core", want.unknown_core, got.unknown_core);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  pcut_in_if  in_if ();
  pcut_out_if out_if ();

  per_core_utilization_tracker dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  share_board board;
  int         send_idle_pct;
  int         recv_stall_pct;
  tick_set_t  sent_ticks [ENTRIES];

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Receiver: check each transfer, then pick ready for the next edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        board.check_report({out_if.entry_used, out_if.busy_hundredths,
                            out_if.updated, out_if.unknown_core});
      end
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic tick_t rand_tick();
    return {$urandom, $urandom};
  endfunction

  task automatic push_sample(input logic [IDX_W-1:0] idx, input tick_set_t t);
    sample_t s;
    s.core_index = idx;
    s.ticks      = t;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.core_index    <= idx;
    in_if.user_ticks    <= t[C_USER];
    in_if.nice_ticks    <= t[C_NICE];
    in_if.system_ticks  <= t[C_SYSTEM];
    in_if.idle_ticks    <= t[C_IDLE];
    in_if.iowait_ticks  <= t[C_IOWAIT];
    in_if.irq_ticks     <= t[C_IRQ];
    in_if.softirq_ticks <= t[C_SOFTIRQ];
    in_if.steal_ticks   <= t[C_STEAL];
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    board.record_sample(s);
    sent_ticks[(idx > CORES) ? 0 : idx] = t;
  endtask

  task automatic run_directed();
    tick_set_t t;
    // Nothing has moved since reset: zero interval on the aggregate.
    push_sample(8'd0, '0);
    t = '0; t[C_USER] = 64'd100;
    push_sample(8'd1, t);
    t = '0; t[C_IDLE] = 64'd100;
    push_sample(8'd2, t);
    t = '0; t[C_USER] = 64'd1; t[C_IDLE] = 64'd2;
    push_sample(8'd3, t);
    push_sample(8'd3, t);
    // Move ticks from busy to idle without changing the total.
    t[C_IDLE] = t[C_IDLE] + 64'd5; t[C_USER] = t[C_USER] - 64'd5;
    push_sample(8'd3, t);
    t = '1;
    push_sample(8'd4, t);
    push_sample(8'd4, '0);
    t = '0; t[C_USER] = '1;
    push_sample(8'd5, t);
    t[C_USER] = 64'd2;
    push_sample(8'd5, t);
    // Idle grows past the total: share drops to zero.
    t = '0; t[C_IDLE] = 64'd1000; t[C_USER] = -64'd990;
    push_sample(8'd6, t);
    t = '0; t[C_USER] = '1;
    push_sample(8'd7, t);
    t[C_IDLE] = 64'h8000_0000_0000_0000; t[C_USER] = t[C_USER] + 64'h4000_0000_0000_0000;
    push_sample(8'd7, t);
    t = '1; t[C_IDLE] = 64'd7;
    push_sample(CORES[IDX_W-1:0], t);
    t = '0; t[C_IRQ] = 64'd40; t[C_IOWAIT] = 64'd10;
    push_sample(IDX_W'(CORES + 1), t);
    t[C_STEAL] = 64'd30;
    push_sample(8'd255, t);
    t[C_SOFTIRQ] = 64'd20;
    push_sample(8'd128, t);
    // Each counter on its own: busy ones give full share, idle and iowait give none.
    for (int c = 0; c < 8; c++) begin
      t = sent_ticks[1];
      t[c] = t[c] + 64'd1 + 64'(c);
      push_sample(8'd1, t);
    end
  endtask

  task automatic run_random();
    sample_kind_e     kind;
    int unsigned      pick;
    int unsigned      e;
    logic [IDX_W-1:0] idx;
    tick_set_t        t;
    tick_t            jump;
    tick_t            d;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      case (n / (NUM_RANDOM / 4))
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 70)      kind = K_STEADY;
      else if (pick < 78) kind = K_HOLD;
      else if (pick < 85) kind = K_JUMP;
      else if (pick < 90) kind = K_IDLE_HEAVY;
      else if (pick < 95) kind = K_STRAY_INDEX;
      else                kind = K_NOISE;
      e   = $urandom_range(0, CORES);
      idx = IDX_W'(e);
      t   = sent_ticks[e];
      case (kind)
        K_STEADY: begin
          for (int c = 0; c < 8; c++)
            if ($urandom_range(0, 2) != 0) t[c] = t[c] + 64'($urandom_range(0, 1000));
        end
        K_HOLD: begin
          d = 64'($urandom_range(0, 1000));
          t[C_IDLE]   = t[C_IDLE] + d;
          t[C_SYSTEM] = t[C_SYSTEM] - d;
        end
        K_JUMP: begin
          for (int c = 0; c < 8; c++) t[c] = t[c] + (rand_tick() >> $urandom_range(0, 40));
        end
        K_IDLE_HEAVY: begin
          jump = 64'($urandom) + 64'd1000;
          d    = 64'($urandom_range(1, 500));
          t[C_IDLE] = t[C_IDLE] + jump;
          t[C_USER] = t[C_USER] - (jump - d);
        end
        K_STRAY_INDEX: begin
          idx = IDX_W'($urandom_range(CORES + 1, 255));
          t   = sent_ticks[0];
          for (int c = 0; c < 8; c++) t[c] = t[c] + 64'($urandom_range(0, 500));
        end
        default: begin
          idx = IDX_W'($urandom_range(0, 255));
          for (int c = 0; c < 8; c++) t[c] = rand_tick();
        end
      endcase
      push_sample(idx, t);
    end
  endtask

  initial begin
    board               = new();
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    foreach (sent_ticks[i]) sent_ticks[i] = '0;
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.core_index    = '0;
    in_if.user_ticks    = '0;
    in_if.nice_ticks    = '0;
    in_if.system_ticks  = '0;
    in_if.idle_ticks    = '0;
    in_if.iowait_ticks  = '0;
    in_if.irq_ticks     = '0;
    in_if.softirq_ticks = '0;
    in_if.steal_ticks   = '0;
    out_if.ready        = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random();
    in_if.valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d reports: %0d updates, %0d zero intervals, %0d idle above total.",
             board.n_checked, board.n_updates, board.n_held, board.n_idle_heavy);
    $display("Samples with an unknown core index: %0d; mismatches: %0d.",
             board.n_stray, board.n_errors);
    if (board.n_errors == 0 && board.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop, several times the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timeout with %0d reports outstanding.", board.pending.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
